### hw/rtl/ffra_pkg.sv
`timescale 1ns / 1ps

package ffra_pkg;

   // Default table depth.
   localparam int DEF_MAX_REGIONS = 32;

   // Field widths.
   localparam int ADDR_W  = 64;
   localparam int ALIGN_W = 6;
   localparam int STAT_W  = 2;

   // One table entry: 65-bit end over 64-bit base.
   localparam int ENTRY_W = 2 * ADDR_W + 1;

   // Operation codes.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_RGN_RD,
      S_RGN_ALIGN,
      S_FIT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_NEXT,
      S_COMMIT,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              latch_req;
      logic              add_write;
      logic              rgn_rd;
      logic              rgn_load;
      logic              r_inc;
      logic              fit_load;
      logic              scan_rd;
      logic              i_inc;
      logic              next_load;
      logic              commit_write;
      logic              stat_load;
      logic [STAT_W-1:0] stat_value;
      logic              rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;
      logic add_full;
      logic r_end;
      logic align_ovf;
      logic fits;
      logic i_end;
      logic overlap;
      logic re_over;
      logic next_ovf;
      logic guard_last;
      logic resv_full;
      logic rsp_busy;
   } dp_status_type;

endpackage

### hw/rtl/ffra_ctrl.sv
`timescale 1ns / 1ps

module ffra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffra_pkg::dp_status_type dp_status,
   output ffra_pkg::cmd_type      cmd
);
   import ffra_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (dp_status.op == OP_ALLOC) begin
               state_in = S_RGN_RD;
            end else begin
               cmd.stat_load = 1'b1;
               if (dp_status.add_full) begin
                  cmd.stat_value = ST_FULL;
               end else begin
                  cmd.add_write  = 1'b1;
                  cmd.stat_value = ST_OK;
               end
               state_in = S_RESP;
            end
         end
         S_RGN_RD: begin
            if (dp_status.r_end) begin
               cmd.stat_load  = 1'b1;
               cmd.stat_value = ST_NOFIT;
               state_in = S_RESP;
            end else begin
               cmd.rgn_rd = 1'b1;
               state_in = S_RGN_ALIGN;
            end
         end
         S_RGN_ALIGN: begin
            if (dp_status.align_ovf) begin
               cmd.r_inc = 1'b1;
               state_in = S_RGN_RD;
            end else begin
               cmd.rgn_load = 1'b1;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if (!dp_status.fits) begin
               cmd.r_inc = 1'b1;
               state_in = S_RGN_RD;
            end else begin
               cmd.fit_load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (dp_status.i_end) begin
               state_in = S_COMMIT;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!dp_status.overlap) begin
               cmd.i_inc = 1'b1;
               state_in = S_SCAN_RD;
            end else if (dp_status.re_over) begin
               cmd.r_inc = 1'b1;
               state_in = S_RGN_RD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // Move past the reserved range, unless that step overflows or the step budget is spent.
            if (dp_status.next_ovf || dp_status.guard_last) begin
               cmd.r_inc = 1'b1;
               state_in = S_RGN_RD;
            end else begin
               cmd.next_load = 1'b1;
               state_in = S_FIT;
            end
         end
         S_COMMIT: begin
            cmd.stat_load = 1'b1;
            if (dp_status.resv_full) begin
               cmd.stat_value = ST_FULL;
            end else begin
               cmd.commit_write = 1'b1;
               cmd.stat_value   = ST_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!dp_status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/ffra_dp.sv
`timescale 1ns / 1ps

module ffra_dp #(
   parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_opcode,
   input  logic [ffra_pkg::ADDR_W-1:0]  req_range_base,
   input  logic [ffra_pkg::ADDR_W-1:0]  req_range_length,
   input  logic                         req_usable,
   input  logic [ffra_pkg::ALIGN_W-1:0] req_align_log2,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ffra_pkg::ADDR_W-1:0]  rsp_address,
   output logic [ffra_pkg::STAT_W-1:0]  rsp_status,
   input  ffra_pkg::cmd_type            cmd,
   output ffra_pkg::dp_status_type      dp_status
);
   import ffra_pkg::*;

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int GW = $clog2(MAX_REGIONS + 2);

   // Tables: {end[64:0], base[63:0]} per entry.
   logic [ENTRY_W-1:0] avail_mem [MAX_REGIONS];
   logic [ENTRY_W-1:0] resv_mem  [MAX_REGIONS];
   logic [ENTRY_W-1:0] avail_rd_ff, resv_rd_ff;

   logic [CW-1:0]        acnt_ff, rcnt_ff, r_ff, i_ff;
   logic [GW-1:0]        guard_ff;
   logic                 op_ff, usable_ff;
   logic [ADDR_W-1:0]    base_ff, len_ff, c_ff;
   logic [ALIGN_W-1:0]   k_ff;
   logic [ADDR_W:0]      lim_ff, ce_ff;
   logic [STAT_W-1:0]    stat_ff;
   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_address_ff;
   logic [STAT_W-1:0]    rsp_status_ff;

   logic [ADDR_W-1:0] mask;
   logic [ADDR_W:0]   add_end, base_up, ce, re_up;
   logic [ADDR_W:0]   a_lim, r_end;
   logic [ADDR_W-1:0] a_base, r_base;
   logic              below, above;

   // Alignment mask, table field split, the adds and the overlap compares.
   always_comb begin
      mask    = ~({ADDR_W{1'b1}} << k_ff);
      add_end = {1'b0, base_ff} + {1'b0, len_ff};
      a_base  = avail_rd_ff[ADDR_W-1:0];
      a_lim   = avail_rd_ff[ENTRY_W-1:ADDR_W];
      r_base  = resv_rd_ff[ADDR_W-1:0];
      r_end   = resv_rd_ff[ENTRY_W-1:ADDR_W];
      base_up = {1'b0, a_base} + {1'b0, mask};
      ce      = {1'b0, c_ff} + {1'b0, len_ff};
      re_up   = {1'b0, r_end[ADDR_W-1:0]} + {1'b0, mask};
      below   = !ce_ff[ADDR_W] && (ce_ff[ADDR_W-1:0] <= r_base);
      above   = !r_end[ADDR_W] && (c_ff >= r_end[ADDR_W-1:0]);
   end

   // Status toward the controller.
   always_comb begin
      dp_status.op        = op_ff;
      dp_status.add_full  = (acnt_ff == CW'(MAX_REGIONS)) ||
                            (!usable_ff && (rcnt_ff == CW'(MAX_REGIONS)));
      dp_status.r_end     = (r_ff == acnt_ff);
      dp_status.align_ovf = base_up[ADDR_W];
      if (ce[ADDR_W]) begin
         dp_status.fits = lim_ff[ADDR_W] && (ce[ADDR_W-1:0] == '0);
      end else begin
         dp_status.fits = lim_ff[ADDR_W] || (ce[ADDR_W-1:0] <= lim_ff[ADDR_W-1:0]);
      end
      dp_status.i_end      = (i_ff == rcnt_ff);
      dp_status.overlap    = !(below || above);
      dp_status.re_over    = r_end[ADDR_W];
      dp_status.next_ovf   = re_up[ADDR_W];
      dp_status.guard_last = (guard_ff == GW'(MAX_REGIONS + 1));
      dp_status.resv_full  = (rcnt_ff == CW'(MAX_REGIONS));
      dp_status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   // Table writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         avail_mem[acnt_ff[AW-1:0]] <= {add_end, base_ff};
         if (!usable_ff) begin
            resv_mem[rcnt_ff[AW-1:0]] <= {add_end, base_ff};
         end
      end
      if (cmd.commit_write) begin
         resv_mem[rcnt_ff[AW-1:0]] <= {ce_ff, c_ff};
      end
      if (cmd.rgn_rd) begin
         avail_rd_ff <= avail_mem[r_ff[AW-1:0]];
      end
      if (cmd.scan_rd) begin
         resv_rd_ff <= resv_mem[i_ff[AW-1:0]];
      end
   end

   // Item and search payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff     <= req_opcode;
         base_ff   <= req_range_base;
         len_ff    <= req_range_length;
         usable_ff <= req_usable;
         k_ff      <= req_align_log2;
      end
      if (cmd.rgn_load) begin
         c_ff   <= base_up[ADDR_W-1:0] & ~mask;
         lim_ff <= a_lim;
      end
      if (cmd.fit_load) begin
         ce_ff <= ce;
      end
      if (cmd.next_load) begin
         c_ff <= re_up[ADDR_W-1:0] & ~mask;
      end
      if (cmd.stat_load) begin
         stat_ff <= cmd.stat_value;
      end
   end

   // Counters: table fills, region index, reserved index, step guard.
   always_ff @(posedge clock) begin
      if (reset) begin
         acnt_ff  <= '0;
         rcnt_ff  <= '0;
         r_ff     <= '0;
         i_ff     <= '0;
         guard_ff <= '0;
      end else begin
         if (cmd.add_write) begin
            acnt_ff <= acnt_ff + CW'(1);
            if (!usable_ff) begin
               rcnt_ff <= rcnt_ff + CW'(1);
            end
         end
         if (cmd.commit_write) begin
            rcnt_ff <= rcnt_ff + CW'(1);
         end
         if (cmd.latch_req) begin
            r_ff <= '0;
         end else if (cmd.r_inc) begin
            r_ff <= r_ff + CW'(1);
         end
         if (cmd.fit_load) begin
            i_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + CW'(1);
         end
         if (cmd.rgn_load) begin
            guard_ff <= '0;
         end else if (cmd.next_load) begin
            guard_ff <= guard_ff + GW'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= stat_ff;
         rsp_address_ff <= (op_ff == OP_ALLOC && stat_ff == ST_OK) ? c_ff : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

### hw/rtl/first_fit_range_allocator_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Item fields
// req_     | in        | req_valid, req_stall | opcode, range_base, range_length,
//          |           |                      | usable, align_log2
// rsp_     | out       | rsp_valid, rsp_stall | address, status
//
// An add item goes through S_ADD and S_RESP to a registered result. An allocate
// item probes the available regions in order; for each it aligns the base up and
// scans the reserved table, stepping past each overlapping reserved range.
// One item is in work at a time; a waiting result does not block acceptance.
// Reset is synchronous and empties both tables at once.

module first_fit_range_allocator_top #(
   parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [ffra_pkg::ADDR_W-1:0]  req_range_base,
   input  logic [ffra_pkg::ADDR_W-1:0]  req_range_length,
   input  logic                         req_usable,
   input  logic [ffra_pkg::ALIGN_W-1:0] req_align_log2,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ffra_pkg::ADDR_W-1:0]  rsp_address,
   output logic [ffra_pkg::STAT_W-1:0]  rsp_status
);
   import ffra_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ffra_dp #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_range_base   (req_range_base),
      .req_range_length (req_range_length),
      .req_usable       (req_usable),
      .req_align_log2   (req_align_log2),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .dp_status        (dp_status)
   );

endmodule

### hw/rtl/ffra_checker.sv
`timescale 1ns / 1ps

module ffra_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ffra_pkg::ADDR_W-1:0]  rsp_address,
   input logic [ffra_pkg::STAT_W-1:0]  rsp_status
);
   import ffra_pkg::*;

   // A result that is held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_address) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only defined status codes appear.
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOFIT || rsp_status == ST_FULL))
      else $error("undefined status code");

   // Any status but ok carries address zero.
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_address == '0)
      else $error("nonzero address on a failed item");

   // Once an item is taken the block is busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted back to back");

   // Reset leaves no result pending.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_address (rsp_address),
   .rsp_status  (rsp_status)
);
